/* src/lasf_pkg.sv */
// Shared types and constants of the load-adaptive switching frequency unit.
`timescale 1ns / 1ps

package lasf_pkg;

	// Width of the DCM threshold register and of the nominal current (20 x threshold).
	localparam int THR_BITS = 11;
	localparam int NOM_BITS = 16;

	// Reset values of the configuration registers.
	localparam int LO_FREQ_RST = 20000;
	localparam int HI_FREQ_RST = 200000;
	localparam int FREQ_STEP_RST = 1000;
	localparam int DCM_THR_RST = 100;

	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LO_FREQ = 2'd0,
		REG_HI_FREQ = 2'd1,
		REG_FREQ_STEP = 2'd2,
		REG_DCM_THR = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_CCM = 2'd0,
		MODE_DCM = 2'd1,
		MODE_BCM = 2'd2
	} mode_t;

	// How the interpolated offset above the low frequency limit is obtained.
	typedef enum logic [1:0] {
		INTERP_ZERO = 2'd0,
		INTERP_FULL = 2'd1,
		INTERP_DIV = 2'd2
	} interp_sel_t;

	typedef struct packed {
		mode_t mode;
		interp_sel_t sel;
	} class_t;

	localparam int CLASS_BITS = $bits(class_t);

	// Nominal current: 20 x threshold, as (thr << 4) + (thr << 2).
	function automatic logic [NOM_BITS-1:0] nominal_of(input logic [THR_BITS-1:0] thr);
		logic [NOM_BITS-1:0] x16;
		logic [NOM_BITS-1:0] x4;
		x16 = {1'b0, thr, 4'b0000};
		x4 = {3'b000, thr, 2'b00};
		return x16 + x4;
	endfunction

endpackage

/* src/lasf_front.sv */
// Front stages: sample register, classification, and the current x span multiply.
`timescale 1ns / 1ps

module lasf_front #(
	parameter int CURRENT_BITS = 16,
	parameter int FREQ_BITS = 20
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [CURRENT_BITS-1:0]          sample,
	input  logic [lasf_pkg::NOM_BITS-1:0]           nominal,
	input  logic [lasf_pkg::THR_BITS-1:0]           thr,
	input  logic [FREQ_BITS-1:0]                    span,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [lasf_pkg::NOM_BITS+FREQ_BITS-1:0] prod,
	output lasf_pkg::class_t                        cls
);

	localparam int NB = lasf_pkg::NOM_BITS;
	localparam int EXT_W = (CURRENT_BITS > NB) ? CURRENT_BITS : NB + 1;

	logic                          v_s1;
	logic signed [CURRENT_BITS-1:0] sample_s1;
	logic                          v_s2;
	logic [NB-1:0]                 cur_s2;
	lasf_pkg::class_t              cls_s2;
	logic                          v_s3;
	logic [NB+FREQ_BITS-1:0]       prod_s3;
	lasf_pkg::class_t              cls_s3;

	logic rdy1, rdy2, rdy3;

	logic signed [EXT_W-1:0] samp_x;
	logic signed [EXT_W-1:0] nom_x;
	logic signed [EXT_W-1:0] thr_x;
	logic                    pos;
	lasf_pkg::class_t        cls_d;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign samp_x = EXT_W'(sample_s1);
	assign nom_x = $signed(EXT_W'(nominal));
	assign thr_x = $signed(EXT_W'(thr));
	assign pos = samp_x > $signed(EXT_W'(0));

	always_comb begin
		if (!pos || nominal == '0) begin
			cls_d.sel = lasf_pkg::INTERP_ZERO;
		end else if (samp_x >= nom_x) begin
			cls_d.sel = lasf_pkg::INTERP_FULL;
		end else begin
			cls_d.sel = lasf_pkg::INTERP_DIV;
		end
		if (!pos) begin
			cls_d.mode = lasf_pkg::MODE_BCM;
		end else if (samp_x <= thr_x) begin
			cls_d.mode = lasf_pkg::MODE_DCM;
		end else begin
			cls_d.mode = lasf_pkg::MODE_CCM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// On the divide path the sample is positive and below the nominal current,
	// so its low NOM_BITS bits hold it exactly.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			sample_s1 <= sample;
		end
		if (rdy2 && v_s1) begin
			cur_s2 <= samp_x[NB-1:0];
			cls_s2 <= cls_d;
		end
		if (rdy3 && v_s2) begin
			prod_s3 <= (NB+FREQ_BITS)'(cur_s2) * (NB+FREQ_BITS)'(span);
			cls_s3 <= cls_s2;
		end
	end

	assign out_valid = v_s3;
	assign prod = prod_s3;
	assign cls = cls_s3;

endmodule

/* src/lasf_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband carried along.
`timescale 1ns / 1ps

module lasf_div_pipe #(
	parameter int DIV_W = 16,
	parameter int STEPS = 20,
	parameter int SIDE_W = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [DIV_W+STEPS-1:0] num,
	input  logic [DIV_W-1:0]       divisor,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DIV_W+STEPS-1:0] acc_out,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int ACC_W = DIV_W + STEPS;

	// The accumulator holds the partial remainder above the bits still to be
	// shifted in; quotient bits enter at the bottom. The top DIV_W bits of num
	// must be below the divisor.
	logic [ACC_W-1:0]  acc_sk [STEPS];
	logic [SIDE_W-1:0] side_sk [STEPS];
	logic              vld_sk [STEPS];
	logic              rdy [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		logic [ACC_W-1:0]  src;
		logic [SIDE_W-1:0] side_src;
		logic              src_v;
		logic [DIV_W:0]    part;
		logic [DIV_W+1:0]  diff;
		logic [ACC_W-1:0]  nxt;

		if (k == 0) begin : g_first
			assign src = num;
			assign side_src = side_in;
			assign src_v = in_valid;
		end else begin : g_next
			assign src = acc_sk[k-1];
			assign side_src = side_sk[k-1];
			assign src_v = vld_sk[k-1];
		end

		if (k == STEPS - 1) begin : g_last
			assign rdy[k] = !vld_sk[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_sk[k] || rdy[k+1];
		end

		assign part = src[ACC_W-1 -: DIV_W+1];
		assign diff = {1'b0, part} - {2'b00, divisor};

		always_comb begin
			if (!diff[DIV_W+1]) begin
				nxt = {diff[DIV_W-1:0], src[STEPS-2:0], 1'b1};
			end else begin
				nxt = {part[DIV_W-1:0], src[STEPS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_sk[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) begin
				acc_sk[k] <= nxt;
				side_sk[k] <= side_src;
			end
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = vld_sk[STEPS-1];
	assign acc_out = acc_sk[STEPS-1];
	assign side_out = side_sk[STEPS-1];

endmodule

/* src/lasf_freq.sv */
// Interpolation stage: picks the offset above the low frequency limit and adds it.
`timescale 1ns / 1ps

module lasf_freq #(
	parameter int FREQ_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FREQ_BITS-1:0] quotient,
	input  lasf_pkg::class_t     cls,
	input  logic [FREQ_BITS-1:0] span,
	input  logic [FREQ_BITS-1:0] lo_freq,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FREQ_BITS-1:0] freq,
	output lasf_pkg::mode_t      mode
);

	logic                 v_s1;
	logic [FREQ_BITS-1:0] freq_s1;
	lasf_pkg::mode_t      mode_s1;
	logic [FREQ_BITS-1:0] interp;
	logic                 rdy1;

	assign rdy1 = !v_s1 || out_ready;
	assign in_ready = rdy1;

	always_comb begin
		case (cls.sel)
			lasf_pkg::INTERP_FULL: interp = span;
			lasf_pkg::INTERP_DIV:  interp = quotient;
			default:               interp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	// The sum never exceeds the larger of the two frequency limits, so it fits the field width.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			freq_s1 <= lo_freq + interp;
			mode_s1 <= cls.mode;
		end
	end

	assign out_valid = v_s1;
	assign freq = freq_s1;
	assign mode = mode_s1;

endmodule

/* src/lasf_round.sv */
// Back stages: rounding down to the step, clamping, and the output register.
`timescale 1ns / 1ps

module lasf_round #(
	parameter int FREQ_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FREQ_BITS-1:0] freq,
	input  logic [FREQ_BITS-1:0] rem,
	input  lasf_pkg::mode_t      mode,
	input  logic [FREQ_BITS-1:0] lo_freq,
	input  logic [FREQ_BITS-1:0] hi_freq,
	input  logic [FREQ_BITS-1:0] freq_step,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FREQ_BITS-1:0] rounded_freq,
	output logic [FREQ_BITS-1:0] applied_freq,
	output lasf_pkg::mode_t      conduction_mode
);

	logic                 v_s1;
	logic [FREQ_BITS-1:0] rounded_s1;
	lasf_pkg::mode_t      mode_s1;
	logic                 v_s2;
	logic [FREQ_BITS-1:0] rounded_s2;
	logic [FREQ_BITS-1:0] applied_s2;
	lasf_pkg::mode_t      mode_s2;
	logic                 rdy1, rdy2;
	logic [FREQ_BITS-1:0] raised;
	logic [FREQ_BITS-1:0] applied_d;

	assign rdy2 = !v_s2 || out_ready;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Raised to the low limit first, then lowered to the high limit, so the
	// high limit wins when the two are inverted.
	assign raised = (rounded_s1 < lo_freq) ? lo_freq : rounded_s1;
	assign applied_d = (raised > hi_freq) ? hi_freq : raised;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// A zero step means no rounding at all.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			rounded_s1 <= (freq_step == '0) ? freq : freq - rem;
			mode_s1 <= mode;
		end
		if (rdy2 && v_s1) begin
			rounded_s2 <= rounded_s1;
			applied_s2 <= applied_d;
			mode_s2 <= mode_s1;
		end
	end

	assign out_valid = v_s2;
	assign rounded_freq = rounded_s2;
	assign applied_freq = applied_s2;
	assign conduction_mode = mode_s2;

endmodule

/* src/load_adaptive_switching_freq_unit.sv */
// Top level of the load-adaptive switching frequency unit.
`timescale 1ns / 1ps

// Takes one signed inductor-current sample (1 mA per LSB) per transfer and
// returns the switching frequency interpolated between the low and high
// frequency limits by the ratio of the sample to 20 x dcm_threshold, rounded
// down to a multiple of freq_step (not at all for a zero step), the same value
// clamped to those limits, and the conduction mode (CCM, DCM or BCM). A new
// sample is taken every clock cycle unless an output stall has backed up to
// the input; the two restoring dividers settle one quotient bit per pipeline
// stage. A stall on the output holds the pipeline, and empty stages still fill
// behind it. The configuration registers must only be written while no
// transfer is in flight.

module load_adaptive_switching_freq_unit #(
	parameter int CURRENT_BITS = 16,
	parameter int FREQ_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lasf_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [FREQ_BITS-1:0]              cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [CURRENT_BITS-1:0]    current_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [FREQ_BITS-1:0]              rounded_freq,
	output logic [FREQ_BITS-1:0]              applied_freq,
	output logic [1:0]                        conduction_mode
);

	localparam int NB = lasf_pkg::NOM_BITS;
	localparam int TB = lasf_pkg::THR_BITS;

	logic [FREQ_BITS-1:0] lo_freq_q;
	logic [FREQ_BITS-1:0] hi_freq_q;
	logic [FREQ_BITS-1:0] freq_step_q;
	logic [TB-1:0]        dcm_thr_q;
	logic [FREQ_BITS-1:0] span_q;
	logic [NB-1:0]        nominal_q;

	logic                    fr_in_ready;
	logic                    fr_valid;
	logic                    fr_ready;
	logic [NB+FREQ_BITS-1:0] fr_prod;
	lasf_pkg::class_t        fr_cls;

	logic                         d1_valid;
	logic                         d1_ready;
	logic [NB+FREQ_BITS-1:0]      d1_acc;
	logic [lasf_pkg::CLASS_BITS-1:0] d1_side;

	logic                 fq_valid;
	logic                 fq_ready;
	logic [FREQ_BITS-1:0] fq_freq;
	lasf_pkg::mode_t      fq_mode;

	logic                   d2_valid;
	logic                   d2_ready;
	logic [2*FREQ_BITS-1:0] d2_acc;
	logic [FREQ_BITS+1:0]   d2_side;

	lasf_pkg::mode_t rd_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_freq_q <= FREQ_BITS'(lasf_pkg::LO_FREQ_RST);
			hi_freq_q <= FREQ_BITS'(lasf_pkg::HI_FREQ_RST);
			freq_step_q <= FREQ_BITS'(lasf_pkg::FREQ_STEP_RST);
			dcm_thr_q <= TB'(lasf_pkg::DCM_THR_RST);
		end else if (cfg_we) begin
			unique case (lasf_pkg::reg_idx_t'(cfg_idx))
				lasf_pkg::REG_LO_FREQ:   lo_freq_q <= cfg_wdata;
				lasf_pkg::REG_HI_FREQ:   hi_freq_q <= cfg_wdata;
				lasf_pkg::REG_FREQ_STEP: freq_step_q <= cfg_wdata;
				lasf_pkg::REG_DCM_THR:   dcm_thr_q <= cfg_wdata[TB-1:0];
				default: ;
			endcase
		end
	end

	// Derived settings are registered; an item first uses them in its second
	// stage, by which time they have followed any write.
	always_ff @(posedge clk) begin
		span_q <= (hi_freq_q >= lo_freq_q) ? hi_freq_q - lo_freq_q : '0;
		nominal_q <= lasf_pkg::nominal_of(dcm_thr_q);
	end

	lasf_front #(
		.CURRENT_BITS(CURRENT_BITS),
		.FREQ_BITS(FREQ_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(fr_in_ready),
		.sample(current_sample),
		.nominal(nominal_q),
		.thr(dcm_thr_q),
		.span(span_q),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.prod(fr_prod),
		.cls(fr_cls)
	);

	assign in_stall = !fr_in_ready;

	// current x span / nominal; only used when the sample is below nominal,
	// which keeps the quotient inside FREQ_BITS.
	lasf_div_pipe #(
		.DIV_W(NB),
		.STEPS(FREQ_BITS),
		.SIDE_W(lasf_pkg::CLASS_BITS)
	) u_div_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fr_valid),
		.in_ready(fr_ready),
		.num(fr_prod),
		.divisor(nominal_q),
		.side_in(fr_cls),
		.out_valid(d1_valid),
		.out_ready(d1_ready),
		.acc_out(d1_acc),
		.side_out(d1_side)
	);

	lasf_freq #(
		.FREQ_BITS(FREQ_BITS)
	) u_freq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(d1_valid),
		.in_ready(d1_ready),
		.quotient(d1_acc[FREQ_BITS-1:0]),
		.cls(lasf_pkg::class_t'(d1_side)),
		.span(span_q),
		.lo_freq(lo_freq_q),
		.out_valid(fq_valid),
		.out_ready(fq_ready),
		.freq(fq_freq),
		.mode(fq_mode)
	);

	// freq mod step; the remainder comes out in the upper half.
	lasf_div_pipe #(
		.DIV_W(FREQ_BITS),
		.STEPS(FREQ_BITS),
		.SIDE_W(FREQ_BITS + 2)
	) u_div_step (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.num({{FREQ_BITS{1'b0}}, fq_freq}),
		.divisor(freq_step_q),
		.side_in({fq_mode, fq_freq}),
		.out_valid(d2_valid),
		.out_ready(d2_ready),
		.acc_out(d2_acc),
		.side_out(d2_side)
	);

	lasf_round #(
		.FREQ_BITS(FREQ_BITS)
	) u_round (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(d2_valid),
		.in_ready(d2_ready),
		.freq(d2_side[FREQ_BITS-1:0]),
		.rem(d2_acc[2*FREQ_BITS-1:FREQ_BITS]),
		.mode(lasf_pkg::mode_t'(d2_side[FREQ_BITS+1:FREQ_BITS])),
		.lo_freq(lo_freq_q),
		.hi_freq(hi_freq_q),
		.freq_step(freq_step_q),
		.out_valid(out_valid),
		.out_ready(!out_stall),
		.rounded_freq(rounded_freq),
		.applied_freq(applied_freq),
		.conduction_mode(rd_mode)
	);

	assign conduction_mode = rd_mode;

endmodule

/* tb/sv/load_adaptive_switching_freq_unit_tb.sv */
// Self-checking testbench for the load-adaptive switching frequency unit.
`timescale 1ns / 1ps

module load_adaptive_switching_freq_unit_tb;

	localparam int CUR_W = 16;
	localparam int FREQ_W = 20;
	localparam int FREQ_TOP = 1000000;
	localparam int THR_TOP = 1638;
	localparam int LONG_HOLD = 250;
	localparam int SETTLE_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [FREQ_W-1:0] rounded;
		logic [FREQ_W-1:0] applied;
		lasf_pkg::mode_t mode;
	} freq_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lasf_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [FREQ_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CUR_W-1:0] current_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FREQ_W-1:0] rounded_freq;
	logic [FREQ_W-1:0] applied_freq;
	logic [1:0] conduction_mode;

	// Shadow copy of the configuration registers.
	logic [FREQ_W-1:0] fmin_cfg = FREQ_W'(lasf_pkg::LO_FREQ_RST);
	logic [FREQ_W-1:0] fmax_cfg = FREQ_W'(lasf_pkg::HI_FREQ_RST);
	logic [FREQ_W-1:0] fstep_cfg = FREQ_W'(lasf_pkg::FREQ_STEP_RST);
	logic [lasf_pkg::THR_BITS-1:0] thr_cfg = lasf_pkg::THR_BITS'(lasf_pkg::DCM_THR_RST);

	int reset_pts[10] = '{0, -1, 1, 100, 101, 1999, 2000, 2001, 32767, -32768};
	int wide_pts[4] = '{1638, 1639, 32759, 32760};

	logic signed [CUR_W-1:0] pending_samples[$];
	freq_result_t freq_expect_q[$];
	freq_result_t freq_want;
	int unsigned n_errors = 0;
	bit quiet = 1'b0;
	int unsigned hold_req = 0;
	int unsigned hold_done = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	longint cycle_count = 0;

	load_adaptive_switching_freq_unit #(
		.CURRENT_BITS(CUR_W),
		.FREQ_BITS(FREQ_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.current_sample(current_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rounded_freq(rounded_freq),
		.applied_freq(applied_freq),
		.conduction_mode(conduction_mode)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Frequency and mode for one current sample under the present settings.
	function automatic freq_result_t predict_freq(input logic signed [CUR_W-1:0] cur);
		freq_result_t res;
		longint amps;
		longint unsigned lo, hi, step, nom, span, interp, f, app;
		amps = cur;
		lo = fmin_cfg;
		hi = fmax_cfg;
		step = fstep_cfg;
		nom = longint'(thr_cfg) * 20;
		span = (hi >= lo) ? hi - lo : 0;
		if (nom == 0 || amps <= 0)
			interp = 0;
		else if (longint'(amps) >= longint'(nom))
			interp = span;
		else
			interp = (longint'(amps) * span) / nom;
		f = lo + interp;
		if (step != 0)
			f = (f / step) * step;
		app = f;
		if (app < lo) app = lo;
		if (app > hi) app = hi;
		res.rounded = f[FREQ_W-1:0];
		res.applied = app[FREQ_W-1:0];
		if (amps <= 0)
			res.mode = lasf_pkg::MODE_BCM;
		else if (amps <= longint'(thr_cfg))
			res.mode = lasf_pkg::MODE_DCM;
		else
			res.mode = lasf_pkg::MODE_CCM;
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sender: offers queued samples, holds the payload while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			current_sample <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				freq_expect_q.push_back(predict_freq(current_sample));
			if (in_valid && in_stall) begin
				// Payload stays put until the transfer happens.
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_samples.size() != 0) begin
				in_valid <= 1'b1;
				current_sample <= pending_samples.pop_front();
				gap_left <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, including the long hold requested by the stimulus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (hold_req != hold_done) begin
			out_stall <= 1'b1;
			stall_left <= LONG_HOLD - 1;
			hold_done <= hold_req;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (freq_expect_q.size() == 0) begin
				$error("unexpected result: rounded_freq=%0d applied_freq=%0d conduction_mode=%0d",
					rounded_freq, applied_freq, conduction_mode);
				n_errors++;
			end else begin
				freq_want = freq_expect_q.pop_front();
				if (rounded_freq !== freq_want.rounded) begin
					$error("rounded_freq: expected %0d, got %0d", freq_want.rounded, rounded_freq);
					n_errors++;
				end
				if (applied_freq !== freq_want.applied) begin
					$error("applied_freq: expected %0d, got %0d", freq_want.applied, applied_freq);
					n_errors++;
				end
				if (conduction_mode !== freq_want.mode) begin
					$error("conduction_mode: expected %0d, got %0d", freq_want.mode,
						conduction_mode);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** load_adaptive_switching_freq_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input lasf_pkg::reg_idx_t idx, input logic [FREQ_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lasf_pkg::REG_LO_FREQ: fmin_cfg = val;
			lasf_pkg::REG_HI_FREQ: fmax_cfg = val;
			lasf_pkg::REG_FREQ_STEP: fstep_cfg = val;
			lasf_pkg::REG_DCM_THR: thr_cfg = val[lasf_pkg::THR_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input int lo, input int hi, input int step, input int thr);
		write_reg(lasf_pkg::REG_LO_FREQ, FREQ_W'(lo));
		write_reg(lasf_pkg::REG_HI_FREQ, FREQ_W'(hi));
		write_reg(lasf_pkg::REG_FREQ_STEP, FREQ_W'(step));
		write_reg(lasf_pkg::REG_DCM_THR, FREQ_W'(thr));
	endtask

	// Every transfer yields one result, so an empty expectation queue means idle.
	task automatic wait_idle(input int settle);
		do @(negedge clk);
		while (pending_samples.size() != 0 || in_valid || freq_expect_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic push_sample(input int amps);
		@(negedge clk);
		pending_samples.push_back(amps[CUR_W-1:0]);
	endtask

	task automatic random_config();
		int lo, hi, step, thr;
		case ($urandom_range(0, 9))
			0: lo = 0;
			1: lo = FREQ_TOP;
			default: lo = $urandom_range(0, 300000);
		endcase
		case ($urandom_range(0, 9))
			0: hi = 0;
			1: hi = FREQ_TOP;
			2: hi = $urandom_range(0, lo);
			default: hi = $urandom_range(lo, FREQ_TOP);
		endcase
		case ($urandom_range(0, 9))
			0: step = 0;
			1: step = 1;
			2: step = $urandom_range(1, FREQ_TOP);
			default: step = $urandom_range(1, 5000);
		endcase
		case ($urandom_range(0, 9))
			0: thr = 0;
			1: thr = THR_TOP;
			2: thr = 1;
			default: thr = $urandom_range(2, THR_TOP - 1);
		endcase
		set_all(lo, hi, step, thr);
	endtask

	// Samples cluster around the mode threshold and the nominal current.
	function automatic int rand_sample();
		int nom;
		nom = int'(thr_cfg) * 20;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom_range(0, 65535);
			3, 4, 5: return $urandom_range(1, (nom > 0) ? nom : 1);
			6: return int'(thr_cfg) + $urandom_range(0, 4) - 2;
			7: return nom + $urandom_range(0, 4) - 2;
			8: return -int'($urandom_range(0, 32768));
			default: begin
				case ($urandom_range(0, 3))
					0: return 32767;
					1: return -32768;
					2: return 0;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: both sides of the mode threshold and the nominal current.
		foreach (reset_pts[i])
			push_sample(reset_pts[i]);
		wait_idle(4);

		// A zero threshold leaves the ratio at zero.
		write_reg(lasf_pkg::REG_DCM_THR, '0);
		push_sample(0);
		push_sample(500);
		push_sample(32767);
		wait_idle(4);

		// Maximum below minimum: zero span, applied value pulled down to the maximum.
		set_all(500000, 100000, 1000, 100);
		push_sample(-3);
		push_sample(5000);
		push_sample(32767);
		wait_idle(4);

		// No step quantisation.
		set_all(20000, 200000, 0, 100);
		push_sample(777);
		push_sample(1999);
		wait_idle(4);

		// Widest range and largest threshold that the bench uses, finest step.
		set_all(0, FREQ_TOP, 1, THR_TOP);
		foreach (wide_pts[i])
			push_sample(wide_pts[i]);
		wait_idle(4);

		for (int phase = 0; phase < 10; phase++) begin
			random_config();
			@(negedge clk);
			quiet = (phase % 3 == 1) || (phase == 4);
			if (phase == 4)
				hold_req = hold_req + 1;
			for (int k = 0; k < 115; k++)
				push_sample(rand_sample());
			wait_idle(4);
			@(negedge clk);
			quiet = 1'b0;
		end

		wait_idle(SETTLE_CYCLES);
		if (n_errors == 0)
			$display("** load_adaptive_switching_freq_unit: PASSED **");
		else
			$display("** load_adaptive_switching_freq_unit: FAILED **");
		$finish;
	end

endmodule
